@@ src/rbsp_pkg.sv @@
// ============================================================================
// rbsp_pkg: shared types and constants of the RBSP bit reader
// Action codes, sequencer states and the words passed between the top level
// and the read engine.
// ============================================================================
`default_nettype none

package rbsp_pkg;

    localparam int VALUE_W = 32;

    // Emulation prevention byte that follows two zero bytes.
    localparam logic [7:0] EPB_BYTE = 8'h03;

    // Exp-Golomb prefix length (leading zeros) at which a read gives up with overrun.
    localparam logic [5:0] MAX_LEAD = 6'd32;

    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_LOAD  = 3'd1,
        ACT_FIXED = 3'd2,
        ACT_UE    = 3'd3,
        ACT_SE    = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_BIT,
        ST_SUM,
        ST_SIGN,
        ST_DONE
    } state_t;

    typedef enum logic {
        PH_FIXED,
        PH_PREFIX
    } phase_t;

    typedef struct packed {
        logic        valid;
        action_t     action;
        logic [5:0]  bit_count;
    } cmd_t;

    typedef struct packed {
        logic                      done;
        logic [VALUE_W-1:0]        uval;
        logic signed [VALUE_W-1:0] sval;
        logic                      overrun;
    } res_t;

    // Bit offset, counted from the MSB, of the lowest set bit of a byte.
    function automatic logic [2:0] stop_offset(input logic [7:0] b);
        logic [2:0] off;
        off = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i])
            begin
                off = 3'(7 - i);
            end
        end
        return off;
    endfunction

endpackage

`default_nettype wire

@@ src/rbsp_exp_golomb_bit_reader.sv @@
// Start, load and unused actions go from idle straight to the done state.
// Reads take one bit per cycle, with a fetch and a check for every byte boundary
// crossed into loaded data and every emulation prevention byte skipped; ue reads
// add a sum step, se reads a sum and a sign step; out_stall holds a word in done.
// One word is in work at a time; a finished word waiting in the output register does
// not hold up acceptance. Reset clears the reader state; the byte buffer is not cleared.
// ============================================================================
// rbsp_exp_golomb_bit_reader: H.264 RBSP bit reader
// Buffers escaped payload bytes and returns fixed-width, ue and se reads with
// the stop-bit test and the RBSP bit position.
// ============================================================================
`default_nettype none

module rbsp_exp_golomb_bit_reader #(
    parameter int BUFFER_BYTES = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic        [2:0]  action,
    input  wire logic        [7:0]  data_byte,
    input  wire logic        [5:0]  bit_count,
    input  wire logic               ask_more_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic             [31:0] unsigned_value,
    output logic signed      [31:0] signed_value,
    output logic                    overrun_flag,
    output logic                    more_syntax,
    output logic             [15:0] rbsp_bits_consumed
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int PW = CW + 3;

    rbsp_pkg::action_t act;
    rbsp_pkg::cmd_t    cmd;
    rbsp_pkg::res_t    res;

    logic          in_accept;
    logic          load_ok;
    logic          start_ok;
    logic          out_free;
    logic          eng_idle;
    logic [CW-1:0] eng_rbi;
    logic [2:0]    eng_bit;
    logic [CW-1:0] eng_skipped;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [PW-1:0] read_pos;
    logic [PW-1:0] rbsp_pos;
    logic          more_now;

    logic [CW-1:0] loaded_reg, loaded_next;
    logic          has_stop_reg, has_stop_next;
    logic [PW-1:0] stop_bit_reg, stop_bit_next;
    logic          ask_reg;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   uval_reg;
    logic [31:0]   sval_reg;
    logic          overrun_reg;
    logic          more_reg;
    logic [15:0]   consumed_reg;

    assign act       = rbsp_pkg::action_t'(action);
    assign in_stall  = !eng_idle;
    assign in_accept = in_valid && !in_stall;
    assign load_ok   = in_accept && (act == rbsp_pkg::ACT_LOAD)
                    && (loaded_reg < CW'(BUFFER_BYTES));
    assign start_ok  = in_accept && (act == rbsp_pkg::ACT_START);
    assign out_free  = !out_valid_reg || !out_stall;

    assign cmd.valid     = in_accept;
    assign cmd.action    = act;
    assign cmd.bit_count = bit_count;

    // The stop bit is the lowest set bit of the last non-zero byte loaded, so it
    // is tracked as bytes arrive rather than searched for on each query.
    always_comb
    begin
        loaded_next   = loaded_reg;
        has_stop_next = has_stop_reg;
        stop_bit_next = stop_bit_reg;
        if (start_ok)
        begin
            loaded_next   = '0;
            has_stop_next = 1'b0;
        end
        else if (load_ok)
        begin
            loaded_next = loaded_reg + CW'(1);
            if (data_byte != 8'd0)
            begin
                has_stop_next = 1'b1;
                stop_bit_next = {loaded_reg, rbsp_pkg::stop_offset(data_byte)};
            end
        end
    end

    assign read_pos = {eng_rbi, eng_bit};
    assign rbsp_pos = {eng_rbi - eng_skipped, eng_bit};
    assign more_now = ask_reg && has_stop_reg && (read_pos < stop_bit_reg);

    always_comb
    begin
        if (res.done && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    rbsp_byte_store #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_ok),
        .wr_addr (loaded_reg[AW-1:0]),
        .wr_data (data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rbsp_read_engine #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW),
        .CW    (CW)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .loaded   (loaded_reg),
        .out_free (out_free),
        .rd_data  (rd_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .idle     (eng_idle),
        .res      (res),
        .rbi      (eng_rbi),
        .bit_pos  (eng_bit),
        .skipped  (eng_skipped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            has_stop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            has_stop_reg  <= has_stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stop_bit_reg <= stop_bit_next;
        if (in_accept)
        begin
            ask_reg <= ask_more_data;
        end
        if (res.done && out_free)
        begin
            uval_reg     <= res.uval;
            sval_reg     <= res.sval;
            overrun_reg  <= res.overrun;
            more_reg     <= more_now;
            consumed_reg <= 16'(rbsp_pos);
        end
    end

    assign out_valid          = out_valid_reg;
    assign unsigned_value     = uval_reg;
    assign signed_value       = signed'(sval_reg);
    assign overrun_flag       = overrun_reg;
    assign more_syntax        = more_reg;
    assign rbsp_bits_consumed = consumed_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("reader took a word but did not go busy");

    a_read_within_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_rbi <= loaded_reg) && (eng_skipped <= eng_rbi))
        else $error("read position ran past the loaded bytes");

    a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
        load_ok |=> loaded_reg == $past(loaded_reg) + CW'(1))
        else $error("accepted load did not advance the fill count");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res.done && !out_free |=> res.done)
        else $error("finished word dropped while the output register was full");

endmodule

`default_nettype wire

@@ src/rbsp_byte_store.sv @@
// ============================================================================
// rbsp_byte_store: payload byte buffer
// Single write port and one registered read port; the read word holds until
// the next read is issued.
// ============================================================================
`default_nettype none

module rbsp_byte_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/rbsp_read_engine.sv @@
// ============================================================================
// rbsp_read_engine: bit-serial read sequencer
// Takes one bit per cycle for fixed reads and Exp-Golomb prefixes and
// suffixes, fetches each new byte from the store, steps over emulation
// prevention bytes, then finishes ue in a sum step, se in sum and sign steps.
// ============================================================================
`default_nettype none

module rbsp_read_engine #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rbsp_pkg::cmd_t    cmd,
    input  wire logic [CW-1:0]     loaded,
    input  wire logic              out_free,
    input  wire logic [7:0]        rd_data,
    output logic                   rd_en,
    output logic      [AW-1:0]     rd_addr,
    output logic                   idle,
    output rbsp_pkg::res_t         res,
    output logic      [CW-1:0]     rbi,
    output logic      [2:0]        bit_pos,
    output logic      [CW-1:0]     skipped
);

    localparam int VW = rbsp_pkg::VALUE_W;

    rbsp_pkg::state_t  state_reg, state_next;
    rbsp_pkg::action_t op_reg, op_next;
    rbsp_pkg::phase_t  phase_reg, phase_next;

    logic [CW-1:0] rbi_reg, rbi_next;
    logic [2:0]    bit_reg, bit_next;
    logic [1:0]    zrun_reg, zrun_next;
    logic [CW-1:0] skipped_reg, skipped_next;
    logic          overrun_reg, overrun_next;
    logic          esc_reg, esc_next;
    logic [5:0]    count_reg, count_next;
    logic [5:0]    lead_reg, lead_next;
    logic [VW-1:0] val_reg, val_next;
    logic          odd_reg, odd_next;

    logic          at_end;
    logic [CW-1:0] rbi_inc;
    logic          inc_in_range;
    logic          cur_bit;
    logic          byte_last;
    logic          is_read;
    logic          escape;
    logic          bit_take;
    logic          bit_finish;
    logic [VW-1:0] code_mask;
    logic [VW:0]   val_plus;

    assign at_end       = rbi_reg >= loaded;
    assign rbi_inc      = rbi_reg + CW'(1);
    assign inc_in_range = rbi_inc < loaded;
    assign cur_bit      = rd_data[3'd7 - bit_reg];
    assign byte_last    = bit_reg == 3'd7;
    assign is_read      = (cmd.action == rbsp_pkg::ACT_FIXED)
                       || (cmd.action == rbsp_pkg::ACT_UE)
                       || (cmd.action == rbsp_pkg::ACT_SE);
    assign escape       = esc_reg && (zrun_reg >= 2'd2) && (rd_data == rbsp_pkg::EPB_BYTE);
    assign bit_take     = (state_reg == rbsp_pkg::ST_BIT) && !at_end
                       && ((phase_reg == rbsp_pkg::PH_PREFIX) || (count_reg != 6'd0));
    assign bit_finish   = (state_reg == rbsp_pkg::ST_BIT) && (phase_reg == rbsp_pkg::PH_FIXED)
                       && ((count_reg == 6'd0) || at_end);
    assign code_mask    = ~({VW{1'b1}} << lead_reg[4:0]);
    assign val_plus     = {1'b0, val_reg} + {{VW{1'b0}}, 1'b1};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbsp_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (is_read)
                    begin
                        state_next = at_end ? rbsp_pkg::ST_BIT : rbsp_pkg::ST_FETCH;
                    end
                    else
                    begin
                        state_next = rbsp_pkg::ST_DONE;
                    end
                end
            end
            rbsp_pkg::ST_FETCH:
            begin
                state_next = rbsp_pkg::ST_CHECK;
            end
            rbsp_pkg::ST_CHECK:
            begin
                state_next = (escape && inc_in_range) ? rbsp_pkg::ST_FETCH : rbsp_pkg::ST_BIT;
            end
            rbsp_pkg::ST_BIT:
            begin
                if (bit_take && byte_last && inc_in_range)
                begin
                    state_next = rbsp_pkg::ST_FETCH;
                end
                else if (bit_finish)
                begin
                    state_next = (op_reg == rbsp_pkg::ACT_FIXED) ? rbsp_pkg::ST_DONE
                                                                 : rbsp_pkg::ST_SUM;
                end
            end
            rbsp_pkg::ST_SUM:
            begin
                state_next = (op_reg == rbsp_pkg::ACT_SE) ? rbsp_pkg::ST_SIGN
                                                          : rbsp_pkg::ST_DONE;
            end
            rbsp_pkg::ST_SIGN:
            begin
                state_next = rbsp_pkg::ST_DONE;
            end
            rbsp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rbsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Reader state and datapath.
    always_comb
    begin
        op_next      = op_reg;
        phase_next   = phase_reg;
        rbi_next     = rbi_reg;
        bit_next     = bit_reg;
        zrun_next    = zrun_reg;
        skipped_next = skipped_reg;
        overrun_next = overrun_reg;
        esc_next     = esc_reg;
        count_next   = count_reg;
        lead_next    = lead_reg;
        val_next     = val_reg;
        odd_next     = odd_reg;
        case (state_reg)
            rbsp_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.action;
                    val_next   = '0;
                    odd_next   = 1'b0;
                    count_next = cmd.bit_count;
                    lead_next  = 6'd0;
                    esc_next   = 1'b0;
                    phase_next = ((cmd.action == rbsp_pkg::ACT_UE)
                               || (cmd.action == rbsp_pkg::ACT_SE))
                               ? rbsp_pkg::PH_PREFIX : rbsp_pkg::PH_FIXED;
                    if (cmd.action == rbsp_pkg::ACT_START)
                    begin
                        rbi_next     = '0;
                        bit_next     = 3'd0;
                        zrun_next    = 2'd0;
                        skipped_next = '0;
                        overrun_next = 1'b0;
                    end
                end
            end
            rbsp_pkg::ST_CHECK:
            begin
                esc_next = 1'b0;
                if (escape)
                begin
                    rbi_next     = rbi_inc;
                    skipped_next = skipped_reg + CW'(1);
                    zrun_next    = 2'd0;
                end
            end
            rbsp_pkg::ST_BIT:
            begin
                if (phase_reg == rbsp_pkg::PH_FIXED)
                begin
                    if (count_reg != 6'd0)
                    begin
                        if (at_end)
                        begin
                            overrun_next = 1'b1;
                        end
                        else
                        begin
                            val_next   = {val_reg[VW-2:0], cur_bit};
                            count_next = count_reg - 6'd1;
                        end
                    end
                end
                else
                begin
                    // The prefix always hands over to a suffix of lead bits; an
                    // empty suffix leaves the value at zero.
                    if (at_end)
                    begin
                        if (lead_reg == 6'd0)
                        begin
                            overrun_next = 1'b1;
                        end
                        count_next = lead_reg;
                        phase_next = rbsp_pkg::PH_FIXED;
                    end
                    else if (lead_reg == rbsp_pkg::MAX_LEAD)
                    begin
                        overrun_next = 1'b1;
                        lead_next    = 6'd0;
                        count_next   = 6'd0;
                        phase_next   = rbsp_pkg::PH_FIXED;
                    end
                    else if (cur_bit)
                    begin
                        count_next = lead_reg;
                        phase_next = rbsp_pkg::PH_FIXED;
                    end
                    else
                    begin
                        lead_next = lead_reg + 6'd1;
                    end
                end
                if (bit_take)
                begin
                    if (byte_last)
                    begin
                        bit_next = 3'd0;
                        if (rd_data == 8'd0)
                        begin
                            zrun_next = (zrun_reg == 2'd3) ? 2'd3 : zrun_reg + 2'd1;
                        end
                        else
                        begin
                            zrun_next = 2'd0;
                        end
                        rbi_next = rbi_inc;
                        esc_next = inc_in_range;
                    end
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
            rbsp_pkg::ST_SUM:
            begin
                val_next = val_reg + code_mask;
            end
            rbsp_pkg::ST_SIGN:
            begin
                odd_next = val_reg[0];
                val_next = val_plus[VW:1];
            end
            default:
            begin
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        rd_en       = state_reg == rbsp_pkg::ST_FETCH;
        rd_addr     = rbi_reg[AW-1:0];
        idle        = state_reg == rbsp_pkg::ST_IDLE;
        res.done    = state_reg == rbsp_pkg::ST_DONE;
        res.overrun = overrun_reg;
        res.uval    = ((op_reg == rbsp_pkg::ACT_FIXED) || (op_reg == rbsp_pkg::ACT_UE))
                    ? val_reg : '0;
        if (op_reg == rbsp_pkg::ACT_SE)
        begin
            res.sval = odd_reg ? signed'(val_reg) : signed'(VW'(0) - val_reg);
        end
        else
        begin
            res.sval = '0;
        end
    end

    assign rbi     = rbi_reg;
    assign bit_pos = bit_reg;
    assign skipped = skipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rbsp_pkg::ST_IDLE;
            rbi_reg     <= '0;
            bit_reg     <= 3'd0;
            zrun_reg    <= 2'd0;
            skipped_reg <= '0;
            overrun_reg <= 1'b0;
            esc_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rbi_reg     <= rbi_next;
            bit_reg     <= bit_next;
            zrun_reg    <= zrun_next;
            skipped_reg <= skipped_next;
            overrun_reg <= overrun_next;
            esc_reg     <= esc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        phase_reg <= phase_next;
        count_reg <= count_next;
        lead_reg  <= lead_next;
        val_reg   <= val_next;
        odd_reg   <= odd_next;
    end

endmodule

`default_nettype wire
